@@ sv/emgbn_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// EMG filter package
// Shared constants, coefficient table and datapath control types for the
// band-pass / mains band-stop biquad cascade.
// ----------------------------------------------------------------------------
package emgbn_pkg;

   localparam int SAMPLE_WIDTH   = 12;
   localparam int OUT_WIDTH      = 24;
   localparam int FRAC_BITS      = 16;
   localparam int OUT_FRAC       = 8;
   localparam int OUT_SHIFT      = FRAC_BITS - OUT_FRAC;
   localparam int ROUND_HALF     = 2 ** (FRAC_BITS - 1);
   localparam int OUT_ROUND      = 2 ** (OUT_SHIFT - 1);

   localparam int TABLE_ROWS     = 16;
   localparam int ROW_IDX_W      = 4;
   localparam int NUM_COEFS      = 5;
   localparam int COL_W          = 3;
   localparam int STEP_W         = 4;

   localparam logic [COL_W-1:0] COL_B0 = 3'd0;
   localparam logic [COL_W-1:0] COL_B1 = 3'd1;
   localparam logic [COL_W-1:0] COL_B2 = 3'd2;
   localparam logic [COL_W-1:0] COL_A1 = 3'd3;
   localparam logic [COL_W-1:0] COL_A2 = 3'd4;

   // b0, b1, b2, a1, a2 in Q3.16; rows beyond the eighth pass straight through
   localparam int COEF_TABLE [TABLE_ROWS][NUM_COEFS] = '{
      '{  1165,    2329,   1165,   3680, 24278 },
      '{ 65536, -131072,  65536, -34500, 26371 },
      '{ 65536,  131072,  65536,  31093, 46587 },
      '{ 65536, -131072,  65536, -64529, 48910 },
      '{ 61370,  -37941,  61370, -38418, 62552 },
      '{ 65536,  -40516,  65536, -40768, 62570 },
      '{ 65536,  -40516,  65536, -37239, 64278 },
      '{ 65536,  -40516,  65536, -42979, 64297 },
      '{ 65536, 0, 0, 0, 0 }, '{ 65536, 0, 0, 0, 0 },
      '{ 65536, 0, 0, 0, 0 }, '{ 65536, 0, 0, 0, 0 },
      '{ 65536, 0, 0, 0, 0 }, '{ 65536, 0, 0, 0, 0 },
      '{ 65536, 0, 0, 0, 0 }, '{ 65536, 0, 0, 0, 0 }
   };

   typedef enum logic [2:0] {
      ACC_NOP,
      ACC_BASE_SUB,
      ACC_SUB,
      ACC_LOAD,
      ACC_ADD
   } acc_op_type;

   typedef struct packed {
      logic       mul_hi;
      logic       plo_load;
      logic       comb_load;
      acc_op_type acc_op;
   } mac_ctrl_type;

endpackage
`default_nettype wire

@@ sv/emgbn_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// EMG filter channels
// Valid/ready channels for raw samples in and filtered samples out.
// ----------------------------------------------------------------------------
interface emgbn_req_if import emgbn_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [SAMPLE_WIDTH-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface emgbn_rsp_if import emgbn_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic signed [OUT_WIDTH-1:0] filtered;

   modport source (output valid, output filtered, input ready);
   modport sink   (input valid, input filtered, output ready);
endinterface
`default_nettype wire

@@ sv/emgbn_mac.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// EMG filter multiply-accumulate
// Two-pass state x coefficient multiplier, per-product rounding to Q.16 and a
// saturating accumulator.
// ----------------------------------------------------------------------------
module emgbn_mac import emgbn_pkg::*; #(
   parameter int STATE_WIDTH = 40,
   parameter int COEF_WIDTH  = 20
) (
   input  wire logic                          clock,
   input  wire mac_ctrl_type                  ctrl,
   input  wire logic signed [STATE_WIDTH-1:0] op_state,
   input  wire logic signed [COEF_WIDTH-1:0]  op_coef,
   input  wire logic signed [STATE_WIDTH-1:0] base,
   output logic signed [STATE_WIDTH-1:0]      acc_sat
);

   localparam int LO_W   = STATE_WIDTH / 2;
   localparam int HI_W   = STATE_WIDTH - LO_W;
   localparam int MA_W   = LO_W + 1;
   localparam int PP_W   = MA_W + COEF_WIDTH;
   localparam int PW     = STATE_WIDTH + COEF_WIDTH;
   localparam int TERM_W = PW - FRAC_BITS;
   localparam int ACC_W  = TERM_W + 2;

   localparam logic signed [ACC_W-1:0] SMAX = ACC_W'({1'b0, {(STATE_WIDTH-1){1'b1}}});
   localparam logic signed [ACC_W-1:0] SMIN = ~SMAX;

   logic signed [HI_W-1:0]   hi_part;
   logic        [LO_W-1:0]   lo_part;
   logic signed [MA_W-1:0]   mul_a;
   logic signed [PP_W-1:0]   mul_in;
   logic signed [PP_W-1:0]   mul_ff;
   logic signed [PP_W-1:0]   plo_ff;
   logic signed [PW-1:0]     comb_in;
   logic signed [PW-1:0]     comb_ff;
   logic signed [TERM_W-1:0] term;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [ACC_W-1:0]  acc_ff;

   assign hi_part = op_state[STATE_WIDTH-1:LO_W];
   assign lo_part = op_state[LO_W-1:0];

   // low half goes in as a positive number, high half keeps the sign
   always_comb begin
      if (ctrl.mul_hi) begin
         mul_a = MA_W'(hi_part);
      end else begin
         mul_a = $signed({1'b0, lo_part});
      end
   end

   assign mul_in  = mul_a * op_coef;
   assign comb_in = (PW'(mul_ff) <<< LO_W) + PW'(plo_ff) + PW'(ROUND_HALF);
   assign term    = comb_ff[PW-1:FRAC_BITS];

   always_comb begin
      case (ctrl.acc_op)
         ACC_BASE_SUB: acc_in = ACC_W'(base) - ACC_W'(term);
         ACC_SUB:      acc_in = acc_ff - ACC_W'(term);
         ACC_LOAD:     acc_in = ACC_W'(term);
         ACC_ADD:      acc_in = acc_ff + ACC_W'(term);
         default:      acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      mul_ff <= mul_in;
      if (ctrl.plo_load) begin
         plo_ff <= mul_ff;
      end
      if (ctrl.comb_load) begin
         comb_ff <= comb_in;
      end
      acc_ff <= acc_in;
   end

   always_comb begin
      if (acc_ff > SMAX) begin
         acc_sat = SMAX[STATE_WIDTH-1:0];
      end else if (acc_ff < SMIN) begin
         acc_sat = SMIN[STATE_WIDTH-1:0];
      end else begin
         acc_sat = acc_ff[STATE_WIDTH-1:0];
      end
   end

endmodule
`default_nettype wire

@@ sv/emg_bandpass_notch_biquad_cascade.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// EMG band-pass and mains band-stop filter
// Eight direct-form-II biquads in cascade on one shared multiply-accumulate,
// delay pairs held in a small synchronous RAM.
// ----------------------------------------------------------------------------
// A new sample is not accepted until the previous one has passed through every
// section. Each section works in the multiply-accumulate unit: five
// coefficient products, each passed twice through one half-width multiplier,
// then rounded and accumulated, with the delay row read for the next section
// in the last step of the section. The input
// is taken only while idle; the finished sample sits in an output register,
// so the next sample is accepted while the previous result waits. Delay state
// clears at reset through per-section valid bits, no clearing pass is needed.
// ----------------------------------------------------------------------------
module emg_bandpass_notch_biquad_cascade import emgbn_pkg::*; #(
   parameter int NUM_SECTIONS = 8,
   parameter int COEF_WIDTH   = 20,
   parameter int STATE_WIDTH  = 40
) (
   input  wire logic     clock,
   input  wire logic     reset,
   emgbn_req_if.sink     req_ch,
   emgbn_rsp_if.source   rsp_ch
);

   localparam int SEC_W = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;
   localparam int ROW_W = 2 * STATE_WIDTH;
   localparam int SHW   = STATE_WIDTH + 1 - OUT_SHIFT;

   // schedule points within one section
   localparam logic [STEP_W-1:0] STEP_T0_ACC    = 4'd3;
   localparam logic [STEP_W-1:0] STEP_T1_ACC    = 4'd5;
   localparam logic [STEP_W-1:0] STEP_X_CAPTURE = 4'd6;
   localparam logic [STEP_W-1:0] STEP_WRITE     = 4'd7;
   localparam logic [STEP_W-1:0] STEP_T3_ACC    = 4'd9;
   localparam logic [STEP_W-1:0] STEP_LAST_COMB = 4'd10;
   localparam logic [STEP_W-1:0] STEP_T4_ACC    = 4'd11;
   localparam logic [STEP_W-1:0] STEP_LAST      = 4'd12;

   localparam logic [2:0] TERM_A1Z1 = 3'd0;
   localparam logic [2:0] TERM_A2Z2 = 3'd1;
   localparam logic [2:0] TERM_B1Z1 = 3'd2;
   localparam logic [2:0] TERM_B2Z2 = 3'd3;

   localparam logic signed [SHW-1:0] OMAX = SHW'({1'b0, {(OUT_WIDTH-1){1'b1}}});
   localparam logic signed [SHW-1:0] OMIN = ~OMAX;

   typedef enum logic [1:0] {ST_IDLE, ST_MAC, ST_OUT} state_type;

   state_type                      state_ff;
   logic [STEP_W-1:0]              step_ff;
   logic [SEC_W-1:0]               sec_ff;
   logic signed [STATE_WIDTH-1:0]  v_ff;
   logic signed [STATE_WIDTH-1:0]  x_ff;
   logic                           rsp_valid_ff;
   logic signed [OUT_WIDTH-1:0]    rsp_filtered_ff;

   logic [ROW_W-1:0]               delay_mem [NUM_SECTIONS];
   logic [ROW_W-1:0]               rd_ff;
   logic                           rd_valid_ff;
   logic [NUM_SECTIONS-1:0]        row_valid_ff;

   logic                           req_fire;
   logic                           sec_last;
   logic                           mem_re;
   logic                           mem_we;
   logic [SEC_W-1:0]               rd_addr;
   logic signed [STATE_WIDTH-1:0]  z1;
   logic signed [STATE_WIDTH-1:0]  z2;
   logic [2:0]                     term_idx;
   logic [COL_W-1:0]               coef_col;
   logic [ROW_IDX_W-1:0]           coef_row;
   logic signed [STATE_WIDTH-1:0]  op_state;
   logic signed [COEF_WIDTH-1:0]   op_coef;
   mac_ctrl_type                   mac_ctrl;
   logic signed [STATE_WIDTH-1:0]  acc_sat;
   logic signed [STATE_WIDTH:0]    out_rnd;
   logic signed [SHW-1:0]          out_shift;
   logic signed [OUT_WIDTH-1:0]    out_sat;

   function automatic logic signed [COEF_WIDTH-1:0] coef_clamp(input int v);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (COEF_WIDTH - 1)) - 1;
      lo = -hi - 1;
      if (longint'(v) > hi) begin
         return COEF_WIDTH'(hi);
      end else if (longint'(v) < lo) begin
         return COEF_WIDTH'(lo);
      end
      return COEF_WIDTH'(v);
   endfunction

   assign req_ch.ready    = !reset && (state_ff == ST_IDLE);
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.filtered = rsp_filtered_ff;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign sec_last = (sec_ff == SEC_W'(NUM_SECTIONS - 1));

   // ---- delay RAM: row s holds {z2, z1} of section s
   assign mem_re  = req_fire
                 || (state_ff == ST_MAC && step_ff == STEP_LAST && !sec_last);
   assign rd_addr = (state_ff == ST_IDLE) ? '0 : sec_ff + 1'b1;
   assign mem_we  = (state_ff == ST_MAC) && (step_ff == STEP_WRITE);

   assign z1 = rd_valid_ff ? rd_ff[STATE_WIDTH-1:0]     : '0;
   assign z2 = rd_valid_ff ? rd_ff[ROW_W-1:STATE_WIDTH] : '0;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         delay_mem[sec_ff] <= {z1, x_ff};
      end
      if (mem_re) begin
         rd_ff <= delay_mem[rd_addr];
      end
   end

   // a row never written reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (mem_we) begin
            row_valid_ff[sec_ff] <= 1'b1;
         end
         if (mem_re) begin
            rd_valid_ff <= row_valid_ff[rd_addr];
         end
      end
   end

   // ---- operand selection: a1*z1, a2*z2, b1*z1, b2*z2, then b0*x
   assign term_idx = step_ff[STEP_W-1:1];
   assign coef_row = ROW_IDX_W'(sec_ff);

   always_comb begin
      case (term_idx)
         TERM_A1Z1: begin op_state = z1;   coef_col = COL_A1; end
         TERM_A2Z2: begin op_state = z2;   coef_col = COL_A2; end
         TERM_B1Z1: begin op_state = z1;   coef_col = COL_B1; end
         TERM_B2Z2: begin op_state = z2;   coef_col = COL_B2; end
         default:   begin op_state = x_ff; coef_col = COL_B0; end
      endcase
   end

   assign op_coef = coef_clamp(COEF_TABLE[coef_row][coef_col]);

   always_comb begin
      mac_ctrl.mul_hi    = step_ff[0];
      mac_ctrl.plo_load  = (state_ff == ST_MAC) && step_ff[0];
      mac_ctrl.comb_load = (state_ff == ST_MAC) && !step_ff[0]
                        && (step_ff != '0) && (step_ff <= STEP_LAST_COMB);
      mac_ctrl.acc_op    = ACC_NOP;
      if (state_ff == ST_MAC) begin
         case (step_ff)
            STEP_T0_ACC: mac_ctrl.acc_op = ACC_BASE_SUB;
            STEP_T1_ACC: mac_ctrl.acc_op = ACC_SUB;
            STEP_WRITE:  mac_ctrl.acc_op = ACC_LOAD;
            STEP_T3_ACC: mac_ctrl.acc_op = ACC_ADD;
            STEP_T4_ACC: mac_ctrl.acc_op = ACC_ADD;
            default:     mac_ctrl.acc_op = ACC_NOP;
         endcase
      end
   end

   emgbn_mac #(
      .STATE_WIDTH (STATE_WIDTH),
      .COEF_WIDTH  (COEF_WIDTH)
   ) u_mac (
      .clock    (clock),
      .ctrl     (mac_ctrl),
      .op_state (op_state),
      .op_coef  (op_coef),
      .base     (v_ff),
      .acc_sat  (acc_sat)
   );

   // ---- output rounding to Q.8 and 24-bit saturation
   always_comb begin
      out_rnd   = (STATE_WIDTH+1)'(v_ff) + (STATE_WIDTH+1)'(OUT_ROUND);
      out_shift = out_rnd[STATE_WIDTH:OUT_SHIFT];
      if (out_shift > OMAX) begin
         out_sat = OMAX[OUT_WIDTH-1:0];
      end else if (out_shift < OMIN) begin
         out_sat = OMIN[OUT_WIDTH-1:0];
      end else begin
         out_sat = out_shift[OUT_WIDTH-1:0];
      end
   end

   // ---- sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         sec_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // in ST_OUT the output register is refilled instead
         if (rsp_ch.valid && rsp_ch.ready && state_ff != ST_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  v_ff     <= $signed(STATE_WIDTH'(req_ch.sample) << FRAC_BITS);
                  sec_ff   <= '0;
                  step_ff  <= '0;
                  state_ff <= ST_MAC;
               end
            end
            ST_MAC: begin
               if (step_ff == STEP_X_CAPTURE) begin
                  x_ff <= acc_sat;
               end
               if (step_ff == STEP_LAST) begin
                  v_ff    <= acc_sat;
                  step_ff <= '0;
                  if (sec_last) begin
                     state_ff <= ST_OUT;
                  end else begin
                     sec_ff <= sec_ff + 1'b1;
                  end
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_OUT: begin
               // hold until the previous transaction has left the output register
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_filtered_ff <= out_sat;
                  rsp_valid_ff    <= 1'b1;
                  state_ff        <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // ---- checks
   a_start_section0: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_MAC && step_ff == '0 && sec_ff == '0))
      else $error("sample accepted but first section not started");

   a_ram_single_port: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("delay RAM read and written in the same cycle");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAC) |-> (step_ff <= STEP_LAST))
      else $error("section step counter out of range");

   a_out_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && rsp_valid_ff && !rsp_ch.ready) |=> (state_ff == ST_OUT))
      else $error("result overwritten before previous transaction taken");

endmodule
`default_nettype wire

@@ tb/emg_bandpass_notch_biquad_cascade_tb.sv @@
// ----------------------------------------------------------------------------
// EMG band-pass / mains band-stop cascade testbench
// Sends raw 12-bit samples over the request channel. A bit-exact fixed-point
// model of the eight-section biquad cascade predicts each filtered sample.
// Every result on the response channel is compared with the oldest
// prediction. Runs directed edge cases first, then random noise, square
// waves, slow drift and mixed traffic, with the sender and receiver idling
// at varying rates.
// ----------------------------------------------------------------------------
module emg_bandpass_notch_biquad_cascade_tb import emgbn_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SECTIONS     = 8;
   localparam int COEF_BITS    = 20;
   localparam int STATE_BITS   = 40;
   localparam int SAMPLE_CYCLES = 13 * SECTIONS + 2;

   typedef enum int {
      BURST_NOISE,
      BURST_SQUARE,
      BURST_DRIFT
   } burst_kind_type;

   logic clock = 1'b0;
   logic reset;

   emgbn_req_if req_bus ();
   emgbn_rsp_if rsp_bus ();

   emg_bandpass_notch_biquad_cascade #(
      .NUM_SECTIONS (SECTIONS),
      .COEF_WIDTH   (COEF_BITS),
      .STATE_WIDTH  (STATE_BITS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   always #1 clock = ~clock;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int fail_count     = 0;
   int result_index   = 0;

   // predicted outputs, oldest first
   logic signed [OUT_WIDTH-1:0] expected_filtered [$];

   // z1 at 2s, z2 at 2s+1, 16 fraction bits
   longint section_state [2*SECTIONS];

   // ------------------------------------------------------------------------
   // fixed-point cascade model
   // ------------------------------------------------------------------------
   function automatic longint clamp_signed(input longint v, input int width);
      longint hi = (longint'(1) <<< (width - 1)) - 1;
      longint lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   function automatic longint coef_at(input int sec, input logic [COL_W-1:0] col);
      return clamp_signed(longint'(COEF_TABLE[sec][col]), COEF_BITS);
   endfunction

   // product rounded half-up back to 16 fraction bits
   function automatic longint round_product(input longint st, input longint c);
      return (st * c + longint'(ROUND_HALF)) >>> FRAC_BITS;
   endfunction

   function automatic logic signed [OUT_WIDTH-1:0] filter_sample(
      input logic [SAMPLE_WIDTH-1:0] raw
   );
      longint v;
      longint z1;
      longint z2;
      longint x;
      v = longint'(raw) <<< FRAC_BITS;
      for (int sec = 0; sec < SECTIONS; sec++) begin
         z1 = section_state[2*sec];
         z2 = section_state[2*sec+1];
         x  = clamp_signed(v - round_product(z1, coef_at(sec, COL_A1))
                             - round_product(z2, coef_at(sec, COL_A2)), STATE_BITS);
         v  = clamp_signed(round_product(x, coef_at(sec, COL_B0))
                           + round_product(z1, coef_at(sec, COL_B1))
                           + round_product(z2, coef_at(sec, COL_B2)), STATE_BITS);
         section_state[2*sec+1] = z1;
         section_state[2*sec]   = x;
      end
      v = clamp_signed((v + longint'(OUT_ROUND)) >>> OUT_SHIFT, OUT_WIDTH);
      return v[OUT_WIDTH-1:0];
   endfunction

   // ------------------------------------------------------------------------
   // reporting and checking
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string what);
      fail_count++;
      $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   always @(posedge clock) begin : result_check
      logic signed [OUT_WIDTH-1:0] want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_filtered.size() == 0) begin
            report_mismatch($sformatf("result %0d (filtered %0d) with no sample pending",
                                      result_index, rsp_bus.filtered));
         end else begin
            want = expected_filtered.pop_front();
            if (rsp_bus.filtered !== want)
               report_mismatch($sformatf("result %0d filtered %0d, expected %0d",
                                         result_index, rsp_bus.filtered, want));
         end
         result_index++;
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   // Called just after a rising edge; returns at the edge that takes the
   // transaction, leaving valid high so back-to-back items need no re-raise.
   task automatic send_sample(input logic [SAMPLE_WIDTH-1:0] value);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.sample <= value;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      expected_filtered.push_back(filter_sample(value));
   endtask

   task automatic drive_burst(input burst_kind_type kind, input int count);
      int half;
      int lo;
      int hi;
      int level;
      int held;
      bit high_half;
      half      = $urandom_range(1, 48);
      held      = 0;
      high_half = bit'($urandom_range(0, 1));
      level     = $urandom_range(0, 4095);
      if ($urandom_range(0, 1)) begin
         lo = 0;
         hi = 4095;
      end else begin
         lo = $urandom_range(0, 2047);
         hi = $urandom_range(2048, 4095);
      end
      for (int i = 0; i < count; i++) begin
         case (kind)
            BURST_NOISE: begin
               case ($urandom_range(0, 15))
                  0:       send_sample(12'd0);
                  1:       send_sample(12'hFFF);
                  default: send_sample(SAMPLE_WIDTH'($urandom_range(0, 4095)));
               endcase
            end
            BURST_SQUARE: begin
               send_sample(SAMPLE_WIDTH'(high_half ? hi : lo));
               if (++held >= half) begin
                  held      = 0;
                  high_half = !high_half;
               end
            end
            default: begin
               level += int'($urandom_range(0, 64)) - 32;
               if (level < 0) level = 0;
               if (level > 4095) level = 4095;
               send_sample(SAMPLE_WIDTH'(level));
            end
         endcase
      end
   endtask

   // bursts of random length; with mixed set, each burst draws its own shape
   task automatic drive_bursts(input burst_kind_type kind, input bit mixed, input int total);
      int len;
      burst_kind_type this_kind;
      while (total > 0) begin
         len = $urandom_range(16, 96);
         if (len > total) len = total;
         this_kind = mixed ? burst_kind_type'($urandom_range(0, 2)) : kind;
         drive_burst(this_kind, len);
         total -= len;
      end
   endtask

   // straight out of reset: zero input must give zero, then an impulse
   task automatic test_zero_state();
      repeat (3) send_sample(12'd0);
      send_sample(12'hFFF);
   endtask

   task automatic test_field_extremes();
      send_sample(12'hAAA);
      send_sample(12'h555);
      send_sample(12'd1);
      send_sample(12'd2047);
      send_sample(12'd2048);
      send_sample(12'hFFE);
   endtask

   // full-scale toggling, the hardest drive for the high-Q sections
   task automatic test_full_scale_toggle();
      for (int i = 0; i < 8; i++) send_sample(i[0] ? 12'hFFF : 12'd0);
   endtask

   task automatic test_full_scale_step();
      send_sample(12'd0);
      repeat (4) send_sample(12'hFFF);
   endtask

   task automatic test_noise();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      drive_bursts(BURST_NOISE, 1'b0, 400);
   endtask

   task automatic test_square_waves();
      send_idle_pct  = 76;
      recv_stall_pct = 0;
      drive_bursts(BURST_SQUARE, 1'b0, 400);
   endtask

   task automatic test_drift();
      send_idle_pct  = 0;
      recv_stall_pct = 76;
      drive_bursts(BURST_DRIFT, 1'b0, 400);
   endtask

   task automatic test_mixed_traffic();
      send_idle_pct  = 29;
      recv_stall_pct = 29;
      drive_bursts(BURST_NOISE, 1'b1, 450);
   endtask

   initial begin
      req_bus.valid  <= 1'b0;
      req_bus.sample <= '0;
      reset          <= 1'b1;
      foreach (section_state[i]) section_state[i] = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_zero_state();
      test_field_extremes();
      test_full_scale_toggle();
      test_full_scale_step();
      test_noise();
      test_square_waves();
      test_drift();
      test_mixed_traffic();

      req_bus.valid <= 1'b0;
      while (expected_filtered.size() != 0) @(posedge clock);
      repeat (3 * SAMPLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // watchdog, several times the slowest expected run
   initial begin
      #4_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
